[rtl/bptc_pkg.sv]
// Shared types, codes and helpers for the barometer compensation core.
// Used by the register block, controller, datapath and top level.
// No dependencies.
package bptc_pkg;

    // Sample kind codes on the input and result channels.
    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // Calibration register indexes (byte address = 4 * index).
    localparam logic [2:0] REG_C1 = 3'd0;
    localparam logic [2:0] REG_C2 = 3'd1;
    localparam logic [2:0] REG_C3 = 3'd2;
    localparam logic [2:0] REG_C4 = 3'd3;
    localparam logic [2:0] REG_C5 = 3'd4;
    localparam logic [2:0] REG_C6 = 3'd5;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef struct packed {
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [15:0] c4;
        logic [15:0] c5;
        logic [15:0] c6;
    } t_cal_words;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_DT,
        ST_T_MUL1,
        ST_T_TEMP,
        ST_T_MUL2,
        ST_T_FIN,
        ST_P_MUL_OFF,
        ST_P_OFF,
        ST_P_MUL_SENS,
        ST_P_SENS,
        ST_P_MUL_D,
        ST_P_SCALE1,
        ST_P_CORR1,
        ST_P_MUL_E,
        ST_P_SCALE2,
        ST_P_CORR2,
        ST_P_MUL_LO,
        ST_P_ACC_LO,
        ST_P_MUL_HI,
        ST_P_ACC_HI,
        ST_P_SUB,
        ST_P_FIN
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_T_DT,
        DP_T_MUL1,
        DP_T_TEMP,
        DP_T_MUL2,
        DP_T_FIN,
        DP_P_MUL_OFF,
        DP_P_OFF,
        DP_P_MUL_SENS,
        DP_P_SENS,
        DP_P_MUL_D,
        DP_P_SCALE1,
        DP_P_CORR1,
        DP_P_MUL_E,
        DP_P_SCALE2,
        DP_P_CORR2,
        DP_P_MUL_LO,
        DP_P_ACC_LO,
        DP_P_MUL_HI,
        DP_P_ACC_HI,
        DP_P_SUB,
        DP_P_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_in;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Clamp a wide signed value to the 24-bit signed result range.
    function automatic logic [23:0] sat_value(input logic signed [63:0] v);
        logic [23:0] res;
        if (v > 64'sd8388607) begin
            res = 24'h7FFFFF;
        end else if (v < -64'sd8388608) begin
            res = 24'h800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

endpackage

[rtl/bptc_cfg_regs.sv]
// APB-style calibration register file: six 16-bit factory words.
// Depends on bptc_pkg for register indexes and the calibration struct.
module bptc_cfg_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [4:0]               i_paddr,
    input  logic [31:0]              i_pwdata,
    output logic [31:0]              o_prdata,
    output logic                     o_pready,
    output bptc_pkg::t_cal_words     o_cal
);
    import bptc_pkg::*;

    t_cal_words r_cal;
    logic [2:0] w_idx;
    logic       w_wr;
    logic [15:0] w_rd_word;

    assign w_idx    = i_paddr[4:2];
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cal    = r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_C1: r_cal.c1 <= i_pwdata[15:0];
                REG_C2: r_cal.c2 <= i_pwdata[15:0];
                REG_C3: r_cal.c3 <= i_pwdata[15:0];
                REG_C4: r_cal.c4 <= i_pwdata[15:0];
                REG_C5: r_cal.c5 <= i_pwdata[15:0];
                REG_C6: r_cal.c6 <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_C1:  w_rd_word = r_cal.c1;
            REG_C2:  w_rd_word = r_cal.c2;
            REG_C3:  w_rd_word = r_cal.c3;
            REG_C4:  w_rd_word = r_cal.c4;
            REG_C5:  w_rd_word = r_cal.c5;
            REG_C6:  w_rd_word = r_cal.c6;
            default: w_rd_word = 16'h0000;
        endcase
    end

    assign o_prdata = {16'h0000, w_rd_word};

endmodule

[rtl/bptc_ctrl.sv]
// Sequencer for the compensation core: steps the datapath through the
// temperature or pressure schedule. Depends on bptc_pkg for states and commands.
module bptc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_operation,
    output logic                 o_ready,
    input  bptc_pkg::t_dp_status i_status,
    output bptc_pkg::t_dp_cmd    o_cmd
);
    import bptc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_operation == OP_TEMP) ? ST_T_DT : ST_P_MUL_OFF;
                end
            end
            ST_T_DT:       n_state = ST_T_MUL1;
            ST_T_MUL1:     n_state = ST_T_TEMP;
            ST_T_TEMP:     n_state = ST_T_MUL2;
            ST_T_MUL2:     n_state = ST_T_FIN;
            ST_T_FIN: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_P_MUL_OFF:  n_state = ST_P_OFF;
            ST_P_OFF:      n_state = ST_P_MUL_SENS;
            ST_P_MUL_SENS: n_state = ST_P_SENS;
            ST_P_SENS:     n_state = ST_P_MUL_D;
            ST_P_MUL_D:    n_state = ST_P_SCALE1;
            ST_P_SCALE1:   n_state = ST_P_CORR1;
            ST_P_CORR1:    n_state = ST_P_MUL_E;
            ST_P_MUL_E:    n_state = ST_P_SCALE2;
            ST_P_SCALE2:   n_state = ST_P_CORR2;
            ST_P_CORR2:    n_state = ST_P_MUL_LO;
            ST_P_MUL_LO:   n_state = ST_P_ACC_LO;
            ST_P_ACC_LO:   n_state = ST_P_MUL_HI;
            ST_P_MUL_HI:   n_state = ST_P_ACC_HI;
            ST_P_ACC_HI:   n_state = ST_P_SUB;
            ST_P_SUB:      n_state = ST_P_FIN;
            ST_P_FIN: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = DP_NOP;
        o_ready        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.load_in = i_valid;
            end
            ST_T_DT:       o_cmd.op = DP_T_DT;
            ST_T_MUL1:     o_cmd.op = DP_T_MUL1;
            ST_T_TEMP:     o_cmd.op = DP_T_TEMP;
            ST_T_MUL2:     o_cmd.op = DP_T_MUL2;
            ST_T_FIN: begin
                o_cmd.op       = DP_T_FIN;
                o_cmd.load_out = i_status.out_free;
            end
            ST_P_MUL_OFF:  o_cmd.op = DP_P_MUL_OFF;
            ST_P_OFF:      o_cmd.op = DP_P_OFF;
            ST_P_MUL_SENS: o_cmd.op = DP_P_MUL_SENS;
            ST_P_SENS:     o_cmd.op = DP_P_SENS;
            ST_P_MUL_D:    o_cmd.op = DP_P_MUL_D;
            ST_P_SCALE1:   o_cmd.op = DP_P_SCALE1;
            ST_P_CORR1:    o_cmd.op = DP_P_CORR1;
            ST_P_MUL_E:    o_cmd.op = DP_P_MUL_E;
            ST_P_SCALE2:   o_cmd.op = DP_P_SCALE2;
            ST_P_CORR2:    o_cmd.op = DP_P_CORR2;
            ST_P_MUL_LO:   o_cmd.op = DP_P_MUL_LO;
            ST_P_ACC_LO:   o_cmd.op = DP_P_ACC_LO;
            ST_P_MUL_HI:   o_cmd.op = DP_P_MUL_HI;
            ST_P_ACC_HI:   o_cmd.op = DP_P_ACC_HI;
            ST_P_SUB:      o_cmd.op = DP_P_SUB;
            ST_P_FIN: begin
                o_cmd.op       = DP_P_FIN;
                o_cmd.load_out = i_status.out_free;
            end
            default:       o_cmd.op = DP_NOP;
        endcase
    end

endmodule

[rtl/bptc_datapath.sv]
// Compensation datapath: one shared 27x27 signed multiplier, working
// registers, stored dT/TEMP and the result register. Depends on bptc_pkg.
module bptc_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bptc_pkg::t_dp_cmd     i_cmd,
    input  logic [23:0]           i_raw_adc,
    input  bptc_pkg::t_cal_words  i_cal,
    input  logic                  i_ready,
    output bptc_pkg::t_dp_status  o_status,
    output logic                  o_valid,
    output logic                  o_result_kind,
    output logic [23:0]           o_value
);
    import bptc_pkg::*;

    logic [23:0]        r_raw;
    logic signed [25:0] r_dt;
    logic signed [18:0] r_temp;
    logic signed [53:0] r_prod;
    logic signed [41:0] r_off;
    logic signed [41:0] r_sens;
    logic signed [41:0] r_sq5;
    logic signed [41:0] r_sq11;
    logic signed [63:0] r_acc;
    logic               r_out_valid;
    logic               r_out_kind;
    logic [23:0]        r_out_value;

    logic signed [26:0] w_mul_a;
    logic signed [26:0] w_mul_b;
    logic signed [53:0] w_mul_p;
    logic               w_mul_en;
    logic signed [19:0] w_d;
    logic signed [19:0] w_e;
    logic               w_temp_low;
    logic               w_very_low;
    logic signed [19:0] w_temp20;
    logic signed [20:0] w_tcorr;
    logic signed [20:0] w_tres;
    logic [23:0]        w_result;

    assign w_d        = $signed({r_temp[18], r_temp}) - 20'sd2000;
    assign w_e        = $signed({r_temp[18], r_temp}) + 20'sd1500;
    assign w_temp_low = (r_temp < 19'sd2000);
    assign w_very_low = (r_temp < -19'sd1500);

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b1;
        case (i_cmd.op)
            DP_T_MUL1: begin
                w_mul_a = 27'(r_dt);
                w_mul_b = $signed({11'b0, i_cal.c6});
            end
            DP_T_MUL2: begin
                w_mul_a = 27'(r_dt);
                w_mul_b = 27'(r_dt);
            end
            DP_P_MUL_OFF: begin
                w_mul_a = 27'(r_dt);
                w_mul_b = $signed({11'b0, i_cal.c4});
            end
            DP_P_MUL_SENS: begin
                w_mul_a = 27'(r_dt);
                w_mul_b = $signed({11'b0, i_cal.c3});
            end
            DP_P_MUL_D: begin
                w_mul_a = 27'(w_d);
                w_mul_b = 27'(w_d);
            end
            DP_P_MUL_E: begin
                w_mul_a = 27'(w_e);
                w_mul_b = 27'(w_e);
            end
            // SENS times the sample is split into a low unsigned slice and
            // a signed high slice, recombined in the accumulator.
            DP_P_MUL_LO: begin
                w_mul_a = $signed({3'b0, r_raw});
                w_mul_b = $signed({1'b0, r_sens[25:0]});
            end
            DP_P_MUL_HI: begin
                w_mul_a = $signed({3'b0, r_raw});
                w_mul_b = 27'($signed(r_sens[41:26]));
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    assign w_mul_p  = w_mul_a * w_mul_b;
    assign w_temp20 = 20'sd2000 + $signed(r_prod[42:23]);
    assign w_tcorr  = $signed({2'b00, r_prod[49:31]});
    assign w_tres   = 21'(r_temp) - (w_temp_low ? w_tcorr : 21'sd0);

    always_comb begin
        if (i_cmd.op == DP_T_FIN) begin
            w_result = sat_value(64'(w_tres));
        end else begin
            w_result = sat_value(r_acc >>> 15);
        end
    end

    // Control and persistent state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt        <= '0;
            r_temp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == DP_T_DT) begin
                r_dt <= $signed({2'b00, r_raw}) - $signed({2'b00, i_cal.c5, 8'h00});
            end
            if (i_cmd.op == DP_T_TEMP) begin
                r_temp <= $signed(w_temp20[18:0]);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_raw <= i_raw_adc;
        end
        if (w_mul_en) begin
            r_prod <= w_mul_p;
        end
        case (i_cmd.op)
            DP_P_OFF: begin
                r_off <= $signed({10'b0, i_cal.c2, 16'h0000}) + $signed(r_prod[48:7]);
            end
            DP_P_SENS: begin
                r_sens <= $signed({11'b0, i_cal.c1, 15'h0000}) + $signed(r_prod[49:8]);
            end
            DP_P_SCALE1: begin
                r_sq5 <= $signed({r_prod[39:0], 2'b00}) + $signed(r_prod[41:0]);
            end
            DP_P_CORR1: begin
                if (w_temp_low) begin
                    r_off  <= r_off - (r_sq5 >>> 1);
                    r_sens <= r_sens - (r_sq5 >>> 2);
                end
            end
            DP_P_SCALE2: begin
                r_sq5  <= $signed({r_prod[38:0], 3'b000}) - $signed(r_prod[41:0]);
                r_sq11 <= $signed({r_prod[38:0], 3'b000}) + $signed({r_prod[40:0], 1'b0})
                          + $signed(r_prod[41:0]);
            end
            DP_P_CORR2: begin
                if (w_very_low) begin
                    r_off  <= r_off - r_sq5;
                    r_sens <= r_sens - (r_sq11 >>> 1);
                end
            end
            DP_P_ACC_LO: begin
                r_acc <= 64'(r_prod);
            end
            DP_P_ACC_HI: begin
                r_acc <= r_acc + $signed({r_prod[37:0], 26'h0000000});
            end
            DP_P_SUB: begin
                r_acc <= (r_acc >>> 21) - 64'(r_off);
            end
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_out_kind  <= (i_cmd.op == DP_T_FIN) ? OP_TEMP : OP_PRESS;
            r_out_value <= w_result;
        end
    end

    assign o_status.out_free = !r_out_valid || i_ready;
    assign o_valid           = r_out_valid;
    assign o_result_kind     = r_out_kind;
    assign o_value           = r_out_value;

endmodule

[rtl/baro_pressure_temp_compensation_core.sv]
// Barometer compensation core: raw 24-bit conversions in, compensated
// temperature (0.01 C) or pressure (Pa) out, one result per transaction.
//
// Input channel (i_valid/o_ready): i_operation selects a temperature (0) or
// pressure (1) sample, i_raw_adc carries the raw conversion. A temperature
// transaction updates the stored dT and first-order temperature; a pressure
// transaction uses the values stored by the last temperature transaction.
// Output channel (o_valid/i_ready): o_result_kind echoes the sample kind and
// o_value is the signed, saturated result.
// A temperature or pressure result is registered at the end of its own
// schedule through the single shared 27x27 multiplier. One item is in work
// at a time; o_ready returns the cycle after the result is loaded, so a new
// item is taken only once the last result is in the output register.
// The output register lets a new item start while a result waits;
// if the receiver stalls, the finished item holds in its last step.
// Reset (synchronous, active low) clears calibration words, stored dT and
// temperature, and the output valid. The user must write calibration over the
// APB port, byte addresses 0..20, only while the core is idle (not enforced).
module baro_pressure_temp_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [23:0] i_raw_adc,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [23:0] o_value
);
    import bptc_pkg::*;

    t_cal_words w_cal;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    bptc_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cal     (w_cal)
    );

    bptc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    bptc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_raw_adc     (i_raw_adc),
        .i_cal         (w_cal),
        .i_ready       (i_ready),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .o_result_kind (o_result_kind),
        .o_value       (o_value)
    );

endmodule

[rtl/bptc_checker.sv]
// Port-level checks for the compensation core, bound to the top level.
// Depends only on the top level's ports.
module bptc_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_result_kind,
    input logic [23:0] o_value
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value) && $stable(o_result_kind))
        else $error("result changed while stalled");

    // Only one item is in work: ready drops right after an accepted transaction.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted again while busy");

    // No result can rise while the first schedule steps (T_DT/T_MUL1 or P_MUL_OFF/P_OFF) run.
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |-> ##1 !$rose(o_valid) ##1 !$rose(o_valid))
        else $error("result appeared too early");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind baro_pressure_temp_compensation_core bptc_port_checks u_bptc_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_result_kind (o_result_kind),
    .o_value       (o_value)
);
